// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// concurrent assertion on the block clock and reset
`define ASSERT_STD(label, prop) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ----- hdl/tssa_pkg.sv -----
`timescale 1ns / 1ps
package tssa_pkg;

  localparam int MAX_DIMS    = 4;
  localparam int EXTENT_BITS = 16;
  localparam int INDEX_BITS  = 32;

  localparam int POS_W    = 32;
  localparam int STATUS_W = 2;
  localparam int DESC_W   = 3 * EXTENT_BITS;
  localparam int CNT_W    = 3;
  localparam int DIM_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // apb map: register i at byte address 8*i
  localparam int REG_IDX_LSB = 3;
  localparam int REG_IDX_W   = $clog2(MAX_DIMS + 1) > 0 ? $clog2(MAX_DIMS + 1) : 1;
  localparam int ADDR_W      = REG_IDX_LSB + REG_IDX_W;
  localparam int APB_DATA_W  = 64;

  localparam logic [REG_IDX_W-1:0] REG_DIM_COUNT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_DESC0     = REG_IDX_W'(1);

  // divider: STEP_BITS quotient bits per stage
  localparam int STEP_BITS  = 4;
  localparam int STEPS      = (INDEX_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_STAGES = MAX_DIMS * STEPS;
  localparam int DQ_W       = STEPS * STEP_BITS;

  localparam int COORD_W = EXTENT_BITS + 1;
  localparam int PROD_W  = INDEX_BITS + EXTENT_BITS;
  localparam int TERM_W  = COORD_W + INDEX_BITS;
  localparam int SUM_W   = TERM_W + DIM_W + 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_BAD_CFG  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic                                valid;
    logic [INDEX_BITS-1:0]               pos;
    logic [DQ_W-1:0]                     dq;
    logic [EXTENT_BITS-1:0]              rem;
    logic [MAX_DIMS-1:0][COORD_W-1:0]    coord;
  } div_t;

endpackage

// ----- hdl/tssa_slice_if.sv -----
`timescale 1ns / 1ps
interface tssa_slice_if;
  logic                         valid;
  logic                         ready;
  logic [tssa_pkg::POS_W-1:0]   slice_position;

  modport source (output valid, output slice_position, input ready);
  modport sink (input valid, input slice_position, output ready);
endinterface

// ----- hdl/tssa_result_if.sv -----
`timescale 1ns / 1ps
interface tssa_result_if;
  logic                            valid;
  logic                            ready;
  logic [tssa_pkg::POS_W-1:0]      source_position;
  logic [tssa_pkg::STATUS_W-1:0]   status_code;

  modport source (output valid, output source_position, output status_code, input ready);
  modport sink (input valid, input source_position, input status_code, output ready);
endinterface

// ----- hdl/tensor_slice_source_address_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Slice gather address generator: each slice_position transfer yields one result with the
// source_position in the input tensor and a status_code (0 ok, 1 beyond slice, 2 bad
// configuration, 3 source overflow; source_position is 0 unless ok). One item is taken every
// cycle unless a full output register that is not taken stalls the whole pipe. The divider
// (4 quotient bits per stage, 8 stages per dimension, 4 dimensions) feeds a multiply stage
// and the output register. Registers are written over APB at byte address 8*i; the user
// must write them only while the block is idle, which the block does not enforce. An item
// may follow a write at once; derived products settle before it reaches the multiply stage.
module tensor_slice_source_address_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [tssa_pkg::ADDR_W-1:0]             paddr,
  input  logic [tssa_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [tssa_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                    pready,
  tssa_slice_if.sink                              slice_i,
  tssa_result_if.source                           result_o
);

  localparam int MD = tssa_pkg::MAX_DIMS;
  localparam int EB = tssa_pkg::EXTENT_BITS;
  localparam int IB = tssa_pkg::INDEX_BITS;

  // configuration registers
  logic [tssa_pkg::CNT_W-1:0]      dim_count_q;
  logic [tssa_pkg::DESC_W-1:0]     desc_q [MD];
  logic [tssa_pkg::REG_IDX_W-1:0]  reg_idx;
  logic [tssa_pkg::DIM_W-1:0]      desc_sel;
  logic                            desc_hit;
  logic                            wr_en;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = paddr[tssa_pkg::ADDR_W-1:tssa_pkg::REG_IDX_LSB];
  assign desc_hit = (reg_idx >= tssa_pkg::REG_DESC0) &&
                    ({1'b0, reg_idx} < ({1'b0, tssa_pkg::REG_DESC0} + (tssa_pkg::REG_IDX_W+1)'(MD)));
  assign desc_sel = tssa_pkg::DIM_W'(reg_idx - tssa_pkg::REG_DESC0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= tssa_pkg::CNT_W'(1);
      for (int j = 0; j < MD; j++) desc_q[j] <= '0;
    end else if (wr_en) begin
      if (reg_idx == tssa_pkg::REG_DIM_COUNT) begin
        dim_count_q <= pwdata[tssa_pkg::CNT_W-1:0];
      end else if (desc_hit) begin
        desc_q[desc_sel] <= pwdata[tssa_pkg::DESC_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == tssa_pkg::REG_DIM_COUNT) begin
      prdata = tssa_pkg::APB_DATA_W'(dim_count_q);
    end else if (desc_hit) begin
      prdata = tssa_pkg::APB_DATA_W'(desc_q[desc_sel]);
    end
  end

  // derived configuration: unused dimensions act as extent 1, begin 0
  logic [EB-1:0]  eff_se [MD];
  logic [EB-1:0]  eff_ie [MD];
  logic [EB-1:0]  eff_bg [MD];
  logic           bad_q;
  logic [IB-1:0]  mat_q [MD];
  logic           mbig_q [MD];
  logic [IB-1:0]  tot_q [MD];
  logic           tbig_q [MD];
  logic           bad_d;

  always_comb begin
    bad_d = (dim_count_q == '0) || (dim_count_q > tssa_pkg::CNT_W'(MD));
    for (int j = 0; j < MD; j++) begin
      if (tssa_pkg::CNT_W'(j) < dim_count_q) begin
        if ((desc_q[j][EB-1:0] == '0) ||
            ({1'b0, desc_q[j][3*EB-1:2*EB]} + {1'b0, desc_q[j][EB-1:0]} >
             {1'b0, desc_q[j][2*EB-1:EB]})) begin
          bad_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MD; j++) begin
      if (tssa_pkg::CNT_W'(j) < dim_count_q) begin
        eff_se[j] = desc_q[j][EB-1:0];
        eff_ie[j] = desc_q[j][2*EB-1:EB];
        eff_bg[j] = desc_q[j][3*EB-1:2*EB];
      end else begin
        eff_se[j] = EB'(1);
        eff_ie[j] = EB'(1);
        eff_bg[j] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q <= bad_d;
  end

  // product chains with sticky overflow flags, at most one multiply per register
  for (genvar g = 0; g < MD; g++) begin : g_chain
    if (g == MD - 1) begin : g_inner
      always_ff @(posedge clk_i) begin
        mat_q[g]  <= IB'(1);
        mbig_q[g] <= 1'b0;
      end
    end else begin : g_outer
      logic [tssa_pkg::PROD_W-1:0] mprod;
      assign mprod = mat_q[g+1] * eff_ie[g+1];
      always_ff @(posedge clk_i) begin
        mat_q[g]  <= mprod[IB-1:0];
        mbig_q[g] <= mbig_q[g+1] || (|mprod[tssa_pkg::PROD_W-1:IB]);
      end
    end
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        tot_q[g]  <= IB'(eff_se[g]);
        tbig_q[g] <= 1'b0;
      end
    end else begin : g_next
      logic [tssa_pkg::PROD_W-1:0] tprod;
      assign tprod = tot_q[g-1] * eff_se[g];
      always_ff @(posedge clk_i) begin
        tot_q[g]  <= tprod[IB-1:0];
        tbig_q[g] <= tbig_q[g-1] || (|tprod[tssa_pkg::PROD_W-1:IB]);
      end
    end
  end

  // pipeline advance: everything moves unless the output register is held
  logic out_valid_q;
  logic adv;
  assign adv           = !out_valid_q || result_o.ready;
  assign slice_i.ready = adv;

  // divider stages, innermost dimension first
  tssa_pkg::div_t div_in;
  tssa_pkg::div_t div_nxt [tssa_pkg::DIV_STAGES];
  tssa_pkg::div_t div_q   [tssa_pkg::DIV_STAGES];

  always_comb begin
    div_in       = '0;
    div_in.valid = slice_i.valid;
    div_in.pos   = slice_i.slice_position[IB-1:0];
    div_in.dq    = tssa_pkg::DQ_W'(slice_i.slice_position[IB-1:0]);
  end

  for (genvar s = 0; s < tssa_pkg::DIV_STAGES; s++) begin : g_div
    localparam int D     = MD - 1 - s / tssa_pkg::STEPS;
    localparam int SUB   = s % tssa_pkg::STEPS;
    tssa_pkg::div_t prev;
    if (s == 0) begin : g_src_in
      assign prev = div_in;
    end else begin : g_src_stage
      assign prev = div_q[s-1];
    end

    always_comb begin : p_step
      logic [EB:0] r2;
      logic        qb;
      div_nxt[s] = prev;
      r2 = '0;
      qb = 1'b0;
      if (SUB == 0) div_nxt[s].rem = '0;
      for (int k = 0; k < tssa_pkg::STEP_BITS; k++) begin
        r2 = {div_nxt[s].rem, div_nxt[s].dq[tssa_pkg::DQ_W-1]};
        qb = (r2 >= {1'b0, eff_se[D]});
        if (qb) begin
          r2 = r2 - {1'b0, eff_se[D]};
        end
        div_nxt[s].rem = r2[EB-1:0];
        div_nxt[s].dq  = {div_nxt[s].dq[tssa_pkg::DQ_W-2:0], qb};
      end
      if (SUB == tssa_pkg::STEPS - 1) begin
        div_nxt[s].coord[D] = {1'b0, eff_bg[D]} + {1'b0, div_nxt[s].rem};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q[s] <= '0;
      end else if (adv) begin
        div_q[s] <= div_nxt[s];
      end
    end
  end

  // multiply stage: coordinate times row pitch
  tssa_pkg::div_t                last;
  logic                          mul_valid_q;
  logic [tssa_pkg::TERM_W-1:0]   term_q [MD];
  logic                          movf_q;
  logic                          range_q;
  logic                          movf_d;

  assign last = div_q[tssa_pkg::DIV_STAGES-1];

  always_comb begin
    movf_d = 1'b0;
    for (int j = 0; j < MD; j++) begin
      if (mbig_q[j] && (last.coord[j] != '0)) movf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (adv) begin
      mul_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < MD; j++) term_q[j] <= last.coord[j] * mat_q[j];
      movf_q  <= movf_d;
      range_q <= !tbig_q[MD-1] && (last.pos >= tot_q[MD-1]);
    end
  end

  // sum and status into the output register
  logic [tssa_pkg::SUM_W-1:0]  sum_d;
  tssa_pkg::status_e           status_d;
  tssa_pkg::status_e           status_q;
  logic [tssa_pkg::POS_W-1:0]  source_q;

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < MD; j++) sum_d = sum_d + tssa_pkg::SUM_W'(term_q[j]);
    priority if (bad_q) begin
      status_d = tssa_pkg::ST_BAD_CFG;
    end else if (range_q) begin
      status_d = tssa_pkg::ST_RANGE;
    end else if (movf_q || (|sum_d[tssa_pkg::SUM_W-1:IB])) begin
      status_d = tssa_pkg::ST_OVERFLOW;
    end else begin
      status_d = tssa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= status_d;
      source_q <= (status_d == tssa_pkg::ST_OK) ? tssa_pkg::POS_W'(sum_d[IB-1:0]) : '0;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.status_code     = status_q;
  assign result_o.source_position = source_q;

  `ASSERT_STD(a_err_zero_src,
    out_valid_q && (status_q != tssa_pkg::ST_OK) |-> source_q == '0)
  `ASSERT_STD(a_stall_freezes,
    !adv |=> $stable(mul_valid_q) && $stable(div_q[0].valid))
  `ASSERT_STD(a_ready_rule,
    slice_i.ready == (!out_valid_q || result_o.ready))

endmodule

// ----- tb/tensor_slice_source_address_core_tb.sv -----
`timescale 1ns / 1ps
module tensor_slice_source_address_core_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 45;

  typedef struct packed {
    tssa_pkg::status_e status;
    logic [31:0]       source;
  } source_addr_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tssa_pkg::ADDR_W-1:0] paddr = '0;
  logic [tssa_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [tssa_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  tssa_slice_if slice_bus ();
  tssa_result_if result_bus ();

  tensor_slice_source_address_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .slice_i  (slice_bus.sink),
    .result_o (result_bus.source)
  );

  always #5 clk_i = ~clk_i;

  // local copy of the register file
  logic [tssa_pkg::CNT_W-1:0]  dim_count_q = tssa_pkg::CNT_W'(1);
  logic [tssa_pkg::DESC_W-1:0] dim_desc_q [tssa_pkg::MAX_DIMS];
  initial for (int i = 0; i < tssa_pkg::MAX_DIMS; i++) dim_desc_q[i] = '0;

  logic [31:0] corner_positions [8] = '{32'd0, 32'd1, 32'd119, 32'd120, 32'd121,
                                        32'hffffffff, 32'h80000000, 32'd57};

  logic [31:0]  pending_positions [$];
  source_addr_t expected_addrs [$];
  int  error_count = 0;
  int  result_count = 0;
  int  cycle_count = 0;
  bit  burst_mode = 1'b0;

  function automatic source_addr_t map_slice_position(logic [31:0] pos);
    source_addr_t res;
    logic [127:0] total, mat, src, rest;
    logic [127:0] se, ie, bg;
    int n;
    res.source = '0;
    total = 1;
    mat = 1;
    src = 0;
    n = dim_count_q;
    if (n == 0 || n > tssa_pkg::MAX_DIMS) begin
      res.status = tssa_pkg::ST_BAD_CFG;
      return res;
    end
    for (int i = 0; i < n; i++) begin
      se = dim_desc_q[i][15:0];
      ie = dim_desc_q[i][31:16];
      bg = dim_desc_q[i][47:32];
      if (se == 0 || bg + se > ie) begin
        res.status = tssa_pkg::ST_BAD_CFG;
        return res;
      end
      total = total * se;
    end
    if (128'(pos) >= total) begin
      res.status = tssa_pkg::ST_RANGE;
      return res;
    end
    rest = 128'(pos);
    for (int i = n - 1; i >= 0; i--) begin
      se = dim_desc_q[i][15:0];
      ie = dim_desc_q[i][31:16];
      bg = dim_desc_q[i][47:32];
      src = src + (bg + rest % se) * mat;
      rest = rest / se;
      mat = mat * ie;
    end
    if ((src >> 32) != 0) begin
      res.status = tssa_pkg::ST_OVERFLOW;
      return res;
    end
    res.status = tssa_pkg::ST_OK;
    res.source = src[31:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (burst_mode || r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      slice_bus.valid <= 1'b0;
      slice_bus.slice_position <= '0;
    end else begin
      if (slice_bus.valid && slice_bus.ready) begin
        expected_addrs.push_back(map_slice_position(slice_bus.slice_position));
        void'(pending_positions.pop_front());
      end
      if (slice_bus.valid && !slice_bus.ready) begin
        slice_bus.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        slice_bus.valid <= 1'b0;
      end else if (pending_positions.size() > 0) begin
        slice_bus.valid <= 1'b1;
        slice_bus.slice_position <= pending_positions[0];
        send_gap <= pick_gap();
      end else begin
        slice_bus.valid <= 1'b0;
      end
    end
  end

  // result monitor
  int  recv_gap = 0;
  int  hold_cycles = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i) begin
    source_addr_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        result_count <= result_count + 1;
        if (expected_addrs.size() == 0) begin
          $error("unexpected result transfer: source_position %0h status_code %0d",
                 result_bus.source_position, result_bus.status_code);
          error_count <= error_count + 1;
        end else begin
          want = expected_addrs.pop_front();
          if (result_bus.status_code !== want.status) begin
            $error("status_code: expected %0d, actual %0d", want.status,
                   result_bus.status_code);
            error_count <= error_count + 1;
          end
          if (result_bus.source_position !== want.source) begin
            $error("source_position: expected %0h, actual %0h", want.source,
                   result_bus.source_position);
            error_count <= error_count + 1;
          end
        end
      end
      // one long back-pressure window so the pipe fills and stalls its input
      if (!hold_done && result_count == 150) begin
        hold_done <= 1'b1;
        hold_cycles <= 300;
        result_bus.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        result_bus.ready <= (hold_cycles == 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(int idx, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tssa_pkg::ADDR_W'(idx * 8);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == 0) dim_count_q = value[tssa_pkg::CNT_W-1:0];
    else if (idx <= tssa_pkg::MAX_DIMS) dim_desc_q[idx-1] = value[tssa_pkg::DESC_W-1:0];
  endtask

  task automatic write_desc(int dim, int se, int ie, int bg);
    logic [15:0] junk;
    junk = 16'($urandom);
    reg_write(dim + 1, {junk, 16'(bg), 16'(ie), 16'(se)});
  endtask

  task automatic wait_drained();
    while (pending_positions.size() > 0 || expected_addrs.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic settle();
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [127:0] slice_total();
    logic [127:0] t;
    t = 1;
    for (int i = 0; i < dim_count_q && i < tssa_pkg::MAX_DIMS; i++)
      t = t * dim_desc_q[i][15:0];
    return t;
  endfunction

  task automatic random_config();
    int kind, n, se, ie, bg;
    kind = $urandom_range(0, 9);
    n = $urandom_range(1, tssa_pkg::MAX_DIMS);
    if (kind == 0) begin
      reg_write(0, 64'($urandom_range(0, 1) ? 0 : $urandom_range(5, 7)));
      return;
    end
    reg_write(0, 64'(n));
    for (int d = 0; d < tssa_pkg::MAX_DIMS; d++) begin
      if (kind == 1 && d == n - 1) begin
        se = $urandom_range(0, 1) ? 0 : $urandom_range(2, 50);
        ie = $urandom_range(1, 60);
        bg = ie - se + $urandom_range(1, 3);
        if (se == 0) bg = 0;
      end else if (kind == 2) begin
        se = 16'hffff;
        ie = 16'hffff;
        bg = 0;
      end else begin
        se = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16'hffff) : $urandom_range(1, 40);
        ie = ($urandom_range(0, 3) == 0) ? $urandom_range(se, 16'hffff)
                                          : se + $urandom_range(0, 60);
        if (ie > 16'hffff) ie = 16'hffff;
        bg = $urandom_range(0, ie - se);
      end
      write_desc(d, se, ie, bg);
    end
  endtask

  task automatic queue_random_positions(int count);
    logic [127:0] t;
    int r;
    t = slice_total();
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 9);
      if (r < 8 && t <= 128'hffffffff && t != 0)
        pending_positions.push_back(32'($urandom) % 32'(t));
      else if (r < 9 && t < 128'hffffffff)
        pending_positions.push_back(32'(t) + 32'($urandom_range(0, 3)));
      else
        pending_positions.push_back($urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // reset config: zero slice extent is a bad configuration
    pending_positions.push_back(32'd0);
    pending_positions.push_back(32'hffffffff);
    wait_drained();

    // four dims, extremes of the position field
    reg_write(0, 64'd4);
    write_desc(0, 3, 5, 2);
    write_desc(1, 4, 4, 0);
    write_desc(2, 2, 7, 5);
    write_desc(3, 5, 9, 1);
    settle();
    foreach (corner_positions[j]) pending_positions.push_back(corner_positions[j]);
    wait_drained();

    // begin plus extent beyond input extent
    write_desc(2, 3, 7, 5);
    settle();
    pending_positions.push_back(32'd0);
    pending_positions.push_back(32'd5);
    wait_drained();

    // dim counts outside the legal range
    reg_write(0, 64'd0);
    settle();
    pending_positions.push_back(32'd0);
    wait_drained();
    reg_write(0, 64'd7);
    reg_write(5, 64'h1234);
    reg_write(6, '1);
    reg_write(7, 64'd3);
    settle();
    pending_positions.push_back(32'd1);
    wait_drained();

    // large extents push the source index past 32 bits
    reg_write(0, 64'd3);
    write_desc(0, 16'h00ff, 16'hffff, 16'hff00);
    write_desc(1, 16'hffff, 16'hffff, 16'h0000);
    write_desc(2, 16'h0001, 16'hffff, 16'hfffe);
    settle();
    pending_positions.push_back(32'd0);
    pending_positions.push_back(32'h00fffffe);
    pending_positions.push_back(32'hfffe);
    wait_drained();

    // full extents on every dim: every 32-bit position is in range
    reg_write(0, 64'd4);
    for (int d = 0; d < tssa_pkg::MAX_DIMS; d++) write_desc(d, 16'hffff, 16'hffff, 0);
    settle();
    @(posedge clk_i);
    burst_mode <= 1'b1;
    queue_random_positions(200);
    wait_drained();
    @(posedge clk_i);
    burst_mode <= 1'b0;

    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      settle();
      @(posedge clk_i);
      burst_mode <= (ph % 4 == 3);
      queue_random_positions(75);
      wait_drained();
    end

    if (error_count == 0 && expected_addrs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tssa_pkg.sv
hdl/tssa_slice_if.sv
hdl/tssa_result_if.sv
hdl/tensor_slice_source_address_core.sv
tb/tensor_slice_source_address_core_tb.sv
